>>> hdl/bayer_bilinear_demosaic_unit_macros.svh
// ----------------------------------------------------------------------------
// Bayer demosaic assertion macros
// Shared concurrent assertion forms, clocked on clk, idle in reset.
// ----------------------------------------------------------------------------
`ifndef BAYER_BILINEAR_DEMOSAIC_UNIT_MACROS_SVH
`define BAYER_BILINEAR_DEMOSAIC_UNIT_MACROS_SVH

// same-cycle implication
`define BBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/bbd_pkg.sv
// ----------------------------------------------------------------------------
// Bayer demosaic package
// Widths, register indexes and shared types of the bilinear demosaic block.
// ----------------------------------------------------------------------------
`default_nettype none

package bbd_pkg;

    localparam int MAX_LINE_WIDTH = 1024;
    localparam int PIX_W          = 8;
    localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
    localparam int ROW_W          = 12;
    localparam int FW_W           = 11;
    localparam int FH_W           = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 12;
    localparam int LINE_W         = 2 * PIX_W;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [FW_W-1:0] FW_RESET = 11'd320;
    localparam logic [FH_W-1:0] FH_RESET = 12'd200;
    localparam logic [FW_W-1:0] FW_MIN   = 11'd3;
    localparam logic [FW_W-1:0] FW_MAX   = 11'(MAX_LINE_WIDTH);
    localparam logic [FH_W-1:0] FH_MIN   = 12'd3;

    typedef logic [PIX_W-1:0] pix_t;

    // [row][col], row 0 is the oldest line, col 2 the newest sample
    typedef pix_t [2:0][2:0] win_t;

    typedef struct packed {
        logic emit;
        logic x_odd;
        logic y_odd;
        logic last;
    } ctl_t;

    typedef struct packed {
        pix_t red;
        pix_t green;
        pix_t blue;
    } rgb_t;

endpackage

`default_nettype wire

>>> hdl/bbd_if.sv
// ----------------------------------------------------------------------------
// Bayer demosaic channel interfaces
// Raw pixel stream, RGB result stream and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbd_raw_if;
    logic                valid;
    logic                ready;
    logic [7:0]          raw_pixel;
    logic                frame_start;

    modport source (output valid, output raw_pixel, output frame_start, input ready);
    modport sink   (input valid, input raw_pixel, input frame_start, output ready);
endinterface

interface bbd_rgb_if;
    logic                valid;
    logic                ready;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic                frame_last;

    modport source (output valid, output red, output green, output blue,
                    output frame_last, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input frame_last, output ready);
endinterface

interface bbd_cfg_if;
    logic                valid;
    logic                ready;
    logic [1:0]          index;
    logic [11:0]         data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/bbd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module bbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/bbd_interp.sv
// ----------------------------------------------------------------------------
// Bayer demosaic interpolator
// Bilinear red/green/blue of the window center from its site parity.
// ----------------------------------------------------------------------------
`default_nettype none

module bbd_interp (
    input  wire bbd_pkg::win_t win,
    input  wire bbd_pkg::ctl_t ctl,
    output      bbd_pkg::rgb_t rgb
);

    bbd_pkg::pix_t c;
    bbd_pkg::pix_t l;
    bbd_pkg::pix_t r;
    bbd_pkg::pix_t t;
    bbd_pkg::pix_t b;
    logic [bbd_pkg::PIX_W+1:0] n4_sum;
    logic [bbd_pkg::PIX_W+1:0] d4_sum;
    logic [bbd_pkg::PIX_W:0]   h2_sum;
    logic [bbd_pkg::PIX_W:0]   v2_sum;
    bbd_pkg::pix_t n4;
    bbd_pkg::pix_t d4;
    bbd_pkg::pix_t h2;
    bbd_pkg::pix_t v2;

    assign c = win[1][1];
    assign l = win[1][0];
    assign r = win[1][2];
    assign t = win[0][1];
    assign b = win[2][1];

    assign n4_sum = 10'(l) + 10'(r) + 10'(t) + 10'(b);
    assign d4_sum = 10'(win[0][0]) + 10'(win[0][2]) + 10'(win[2][0]) + 10'(win[2][2]);
    assign h2_sum = 9'(l) + 9'(r);
    assign v2_sum = 9'(t) + 9'(b);

    assign n4 = n4_sum[bbd_pkg::PIX_W+1:2];
    assign d4 = d4_sum[bbd_pkg::PIX_W+1:2];
    assign h2 = h2_sum[bbd_pkg::PIX_W:1];
    assign v2 = v2_sum[bbd_pkg::PIX_W:1];

    always_comb
    begin
        unique case ({ctl.y_odd, ctl.x_odd})
            2'b11:   rgb = '{red: c,  green: n4, blue: d4};
            2'b10:   rgb = '{red: h2, green: c,  blue: v2};
            2'b01:   rgb = '{red: v2, green: c,  blue: h2};
            default: rgb = '{red: d4, green: n4, blue: c};
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/bayer_bilinear_demosaic_unit.sv
// The pixel that completes a 3x3 window (one line and one pixel after its center
//   pixel) is held in the s1 register, and its result then in the result register.
// Throughput: one pixel per cycle unless the output stalls; the line store RAM is
//   read at transfer, written from s1, bypassed for a back-to-back same-address pair.
// Reset clears counters, window, configuration and valid flags; line stores are not
//   cleared, so the first frame must begin with frame_start.
// ----------------------------------------------------------------------------
// Bayer bilinear demosaic unit
// Raw Bayer stream in, RGB of every interior pixel out, two line stores.
// ----------------------------------------------------------------------------
`default_nettype none

module bayer_bilinear_demosaic_unit (
    input wire logic  clk,
    input wire logic  rst_n,
    bbd_raw_if.sink   raw,
    bbd_rgb_if.source rgb,
    bbd_cfg_if.sink   cfg
);

    logic [bbd_pkg::FW_W-1:0]  fw_reg;
    logic [bbd_pkg::FH_W-1:0]  fh_reg;
    logic [bbd_pkg::FW_W-1:0]  eff_w;
    logic [bbd_pkg::FH_W-1:0]  eff_h;

    logic [bbd_pkg::COL_W-1:0] col_reg;
    logic [bbd_pkg::ROW_W-1:0] row_reg;
    logic [bbd_pkg::COL_W-1:0] col_next;
    logic [bbd_pkg::ROW_W-1:0] row_next;
    logic [bbd_pkg::COL_W-1:0] cur_col;
    logic [bbd_pkg::ROW_W-1:0] cur_row;
    logic [bbd_pkg::FW_W-1:0]  col_inc;
    logic [bbd_pkg::ROW_W:0]   row_inc;

    logic                      accept;
    logic                      s1_go;
    logic                      s1_valid_reg;
    bbd_pkg::pix_t             s1_px_reg;
    logic [bbd_pkg::COL_W-1:0] s1_col_reg;
    bbd_pkg::ctl_t             s1_ctl_reg;
    bbd_pkg::ctl_t             ctl_next;

    logic                       byp_reg;
    logic [bbd_pkg::LINE_W-1:0] byp_data_reg;
    logic [bbd_pkg::LINE_W-1:0] ram_q;
    logic [bbd_pkg::LINE_W-1:0] line_q;
    logic [bbd_pkg::LINE_W-1:0] line_wdata;
    bbd_pkg::pix_t              s1_up;
    bbd_pkg::pix_t              s1_mid;

    bbd_pkg::win_t win_reg;
    bbd_pkg::win_t win_next;
    bbd_pkg::rgb_t rgb_calc;

    logic          out_valid_reg;
    bbd_pkg::rgb_t out_rgb_reg;
    logic          out_last_reg;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= bbd_pkg::FW_RESET;
            fh_reg <= bbd_pkg::FH_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == bbd_pkg::REG_FRAME_WIDTH)
            begin
                fw_reg <= cfg.data[bbd_pkg::FW_W-1:0];
            end
            else if (cfg.index == bbd_pkg::REG_FRAME_HEIGHT)
            begin
                fh_reg <= cfg.data[bbd_pkg::FH_W-1:0];
            end
        end
    end

    always_comb
    begin
        priority if (fw_reg < bbd_pkg::FW_MIN)
            eff_w = bbd_pkg::FW_MIN;
        else if (fw_reg > bbd_pkg::FW_MAX)
            eff_w = bbd_pkg::FW_MAX;
        else
            eff_w = fw_reg;
    end

    assign eff_h = (fh_reg < bbd_pkg::FH_MIN) ? bbd_pkg::FH_MIN : fh_reg;

    // handshake
    assign s1_go     = s1_valid_reg && (!out_valid_reg || rgb.ready);
    assign raw.ready = !s1_valid_reg || s1_go;
    assign accept    = raw.valid && raw.ready;

    // position counters
    assign cur_col = raw.frame_start ? '0 : col_reg;
    assign cur_row = raw.frame_start ? '0 : row_reg;
    assign col_inc = bbd_pkg::FW_W'(cur_col) + 1'b1;
    assign row_inc = (bbd_pkg::ROW_W + 1)'(cur_row) + 1'b1;

    always_comb
    begin
        col_next = col_inc[bbd_pkg::COL_W-1:0];
        row_next = cur_row;
        if (col_inc >= eff_w)
        begin
            col_next = '0;
            row_next = (row_inc >= (bbd_pkg::ROW_W + 1)'(eff_h)) ? '0
                                                                 : row_inc[bbd_pkg::ROW_W-1:0];
        end
    end

    assign ctl_next.emit  = (cur_row >= bbd_pkg::ROW_W'(2)) && (cur_col >= bbd_pkg::COL_W'(2));
    assign ctl_next.x_odd = ~cur_col[0];
    assign ctl_next.y_odd = ~cur_row[0];
    assign ctl_next.last  = (cur_row == eff_h - 1'b1)
                         && (bbd_pkg::FW_W'(cur_col) == eff_w - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                byp_reg <= s1_go && (s1_col_reg == cur_col);
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg    <= raw.raw_pixel;
            s1_col_reg   <= cur_col;
            s1_ctl_reg   <= ctl_next;
            byp_data_reg <= line_wdata;
        end
    end

    // line stores: upper in the high byte, middle in the low byte
    assign line_q     = byp_reg ? byp_data_reg : ram_q;
    assign s1_up      = line_q[bbd_pkg::LINE_W-1:bbd_pkg::PIX_W];
    assign s1_mid     = line_q[bbd_pkg::PIX_W-1:0];
    assign line_wdata = {s1_mid, s1_px_reg};

    bbd_ram #(
        .WIDTH (bbd_pkg::LINE_W),
        .DEPTH (bbd_pkg::MAX_LINE_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_col_reg),
        .wdata (line_wdata),
        .re    (accept),
        .raddr (cur_col),
        .rdata (ram_q)
    );

    // window shift
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = s1_up;
        win_next[1][2] = s1_mid;
        win_next[2][2] = s1_px_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (s1_go)
            win_reg <= win_next;
    end

    bbd_interp u_interp (
        .win (win_next),
        .ctl (s1_ctl_reg),
        .rgb (rgb_calc)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go && s1_ctl_reg.emit)
            out_valid_reg <= 1'b1;
        else if (rgb.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_ctl_reg.emit)
        begin
            out_rgb_reg  <= rgb_calc;
            out_last_reg <= s1_ctl_reg.last;
        end
    end

    assign rgb.valid      = out_valid_reg;
    assign rgb.red        = out_rgb_reg.red;
    assign rgb.green      = out_rgb_reg.green;
    assign rgb.blue       = out_rgb_reg.blue;
    assign rgb.frame_last = out_last_reg;

endmodule

`default_nettype wire

>>> hdl/bbd_checker.sv
// ----------------------------------------------------------------------------
// Bayer demosaic port checker
// Port-level properties of the demosaic unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bayer_bilinear_demosaic_unit_macros.svh"

module bbd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       raw_ready,
    input wire logic       rgb_valid,
    input wire logic       rgb_ready,
    input wire logic [7:0] red,
    input wire logic [7:0] green,
    input wire logic [7:0] blue,
    input wire logic       frame_last
);

    logic        out_stall;
    logic [24:0] out_bus;

    assign out_stall = rgb_valid && !rgb_ready;
    assign out_bus   = {red, green, blue, frame_last};

    `BBD_ASSERT_NEXT(a_out_hold, out_stall, rgb_valid, "result dropped while stalled")
    `BBD_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_bus), "stalled result changed")
    `BBD_ASSERT_NOW(a_ready_when_empty, !rgb_valid, raw_ready, "input blocked with empty output")
    `BBD_ASSERT_NOW(a_block_only_on_stall, !raw_ready, out_stall, "input blocked without stall")

endmodule

bind bayer_bilinear_demosaic_unit bbd_checker u_bbd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .raw_ready  (raw.ready),
    .rgb_valid  (rgb.valid),
    .rgb_ready  (rgb.ready),
    .red        (rgb.red),
    .green      (rgb.green),
    .blue       (rgb.blue),
    .frame_last (rgb.frame_last)
);

`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Bayer bilinear demosaic unit testbench
// Streams directed and random raw Bayer frames into the demosaic unit under
// random source and sink stalls, predicts the RGB of every interior pixel with
// an in-bench line store and window model, and checks each result transfer in
// order against it. Frame geometry is changed between phases.
// ----------------------------------------------------------------------------
module testbench;
    import bbd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        pix_t px;
        logic fs;
    } raw_item_t;

    typedef struct packed {
        rgb_t rgb;
        logic last;
    } rgb_result_t;

    logic clk = 1'b0;
    logic rst_n;

    bbd_raw_if raw_ch();
    bbd_rgb_if rgb_ch();
    bbd_cfg_if cfg_ch();

    bayer_bilinear_demosaic_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw_ch),
        .rgb   (rgb_ch),
        .cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    raw_item_t   pending_raw[$];
    rgb_result_t expected_rgb[$];

    pix_t             upper_line[MAX_LINE_WIDTH];
    pix_t             middle_line[MAX_LINE_WIDTH];
    win_t             win_shadow;
    logic [COL_W-1:0] col_pos;
    logic [ROW_W-1:0] row_pos;
    logic [FW_W-1:0]  width_shadow;
    logic [FH_W-1:0]  height_shadow;

    int   send_idle_pct;
    int   recv_idle_pct;
    logic sink_hold;
    int   error_count;
    int   result_count;
    int   pixel_count;
    int   frame_end_count;
    int   cfg_count;

    function automatic int active_width(input logic [FW_W-1:0] w);
        if (w < FW_MIN)
        begin
            return FW_MIN;
        end
        if (w > FW_MAX)
        begin
            return FW_MAX;
        end
        return w;
    endfunction

    function automatic int active_height(input logic [FH_W-1:0] h);
        return (h < FH_MIN) ? FH_MIN : h;
    endfunction

    // advances the model by one raw pixel; returns 1 when an interior pixel is due
    function automatic logic demosaic_pixel(input raw_item_t item, output rgb_result_t res);
        int   w;
        int   h;
        int   col;
        int   row;
        int   c;
        int   l;
        int   r;
        int   t;
        int   b;
        int   n4;
        int   d4;
        int   horiz;
        int   vert;
        pix_t up;
        pix_t mid;
        logic emit;
        w = active_width(width_shadow);
        h = active_height(height_shadow);
        if (item.fs)
        begin
            col_pos = '0;
            row_pos = '0;
        end
        col = col_pos;
        row = row_pos;
        up  = upper_line[col];
        mid = middle_line[col];
        upper_line[col]  = mid;
        middle_line[col] = item.px;
        for (int i = 0; i < 3; i++)
        begin
            win_shadow[i][0] = win_shadow[i][1];
            win_shadow[i][1] = win_shadow[i][2];
        end
        win_shadow[0][2] = up;
        win_shadow[1][2] = mid;
        win_shadow[2][2] = item.px;
        emit = (row >= 2) && (col >= 2);
        res  = '0;
        if (emit)
        begin
            c = win_shadow[1][1];
            l = win_shadow[1][0];
            r = win_shadow[1][2];
            t = win_shadow[0][1];
            b = win_shadow[2][1];
            n4 = (l + r + t + b) >> 2;
            d4 = (win_shadow[0][0] + win_shadow[0][2] +
                  win_shadow[2][0] + win_shadow[2][2]) >> 2;
            horiz = (l + r) >> 1;
            vert  = (t + b) >> 1;
            // center sits one row and one column behind the counters
            case ({row[0], col[0]})
                2'b00:
                begin
                    res.rgb = '{pix_t'(c), pix_t'(n4), pix_t'(d4)};
                end
                2'b01:
                begin
                    res.rgb = '{pix_t'(horiz), pix_t'(c), pix_t'(vert)};
                end
                2'b10:
                begin
                    res.rgb = '{pix_t'(vert), pix_t'(c), pix_t'(horiz)};
                end
                default:
                begin
                    res.rgb = '{pix_t'(d4), pix_t'(n4), pix_t'(c)};
                end
            endcase
            res.last = (row == h - 1) && (col == w - 1);
        end
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= h)
            begin
                row = 0;
            end
        end
        col_pos = COL_W'(col);
        row_pos = ROW_W'(row);
        return emit;
    endfunction

    always @(posedge clk)
    begin : raw_driver
        raw_item_t   item;
        rgb_result_t res;
        if (!rst_n)
        begin
            raw_ch.valid <= 1'b0;
        end
        else
        begin
            if (raw_ch.valid && raw_ch.ready)
            begin
                item = pending_raw.pop_front();
                pixel_count++;
                if (demosaic_pixel(item, res))
                begin
                    expected_rgb.push_back(res);
                end
            end
            if (pending_raw.size() > 0 &&
                ((raw_ch.valid && !raw_ch.ready) || $urandom_range(99) >= send_idle_pct))
            begin
                raw_ch.valid       <= 1'b1;
                raw_ch.raw_pixel   <= pending_raw[0].px;
                raw_ch.frame_start <= pending_raw[0].fs;
            end
            else
            begin
                raw_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : rgb_monitor
        rgb_result_t want;
        if (!rst_n)
        begin
            rgb_ch.ready <= 1'b0;
        end
        else
        begin
            if (rgb_ch.valid && rgb_ch.ready)
            begin
                result_count++;
                if (expected_rgb.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("unexpected rgb transfer: r=%0d g=%0d b=%0d last=%0d",
                                 rgb_ch.red, rgb_ch.green, rgb_ch.blue, rgb_ch.frame_last);
                    end
                end
                else
                begin
                    want = expected_rgb.pop_front();
                    if (want.last)
                    begin
                        frame_end_count++;
                    end
                    if (rgb_ch.red !== want.rgb.red || rgb_ch.green !== want.rgb.green ||
                        rgb_ch.blue !== want.rgb.blue || rgb_ch.frame_last !== want.last)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                        begin
                            $display({"rgb mismatch #%0d: expected r=%0d g=%0d b=%0d last=%0d,",
                                      " got r=%0d g=%0d b=%0d last=%0d"},
                                     result_count, want.rgb.red, want.rgb.green, want.rgb.blue,
                                     want.last, rgb_ch.red, rgb_ch.green, rgb_ch.blue,
                                     rgb_ch.frame_last);
                        end
                    end
                end
            end
            rgb_ch.ready <= !sink_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:
            begin
                width_shadow = value[FW_W-1:0];
            end
            REG_FRAME_HEIGHT:
            begin
                height_shadow = value[FH_W-1:0];
            end
            default:
            begin
            end
        endcase
        cfg_count++;
    endtask

    task automatic queue_pixel(input pix_t px, input logic fs);
        raw_item_t item;
        item.px = px;
        item.fs = fs;
        pending_raw.push_back(item);
    endtask

    task automatic queue_pixels(input int count, input logic fresh_start, input int restart_pct);
        pix_t px;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(9))
                0:
                begin
                    px = 8'h00;
                end
                1:
                begin
                    px = 8'hFF;
                end
                default:
                begin
                    px = pix_t'($urandom);
                end
            endcase
            queue_pixel(px, (k == 0) ? fresh_start : ($urandom_range(99) < restart_pct));
        end
    endtask

    task automatic drain_all();
        while (pending_raw.size() > 0 || expected_rgb.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int   w_pick;
        int   h_pick;
        logic fresh_start;
        rst_n              = 1'b0;
        raw_ch.valid       = 1'b0;
        raw_ch.raw_pixel   = '0;
        raw_ch.frame_start = 1'b0;
        rgb_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_FRAME_WIDTH;
        cfg_ch.data        = '0;
        sink_hold          = 1'b0;
        send_idle_pct      = 24;
        recv_idle_pct      = 69;
        error_count        = 0;
        result_count       = 0;
        pixel_count        = 0;
        frame_end_count    = 0;
        cfg_count          = 0;
        width_shadow       = FW_RESET;
        height_shadow      = FH_RESET;
        col_pos            = '0;
        row_pos            = '0;
        win_shadow         = '0;
        foreach (upper_line[i])
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // reset geometry: part of the first line, a border row gives no result
        queue_pixels(16, 1'b1, 0);
        drain_all();

        // clamped minimum geometry, applied while the counters sit past it
        write_reg(REG_FRAME_WIDTH, 12'd1);
        write_reg(REG_FRAME_HEIGHT, 12'd0);
        write_reg(REG_SPARE_2, 12'hFFF);
        write_reg(REG_SPARE_3, 12'h555);
        queue_pixel(8'hA5, 1'b0);
        for (int k = 0; k < 9; k++)
        begin
            queue_pixel(8'hFF, k == 0);
        end
        drain_all();

        // 4x4 frame entered by wrap-around, covers all four site colors
        write_reg(REG_FRAME_WIDTH, 12'd4);
        write_reg(REG_FRAME_HEIGHT, 12'd4);
        for (int k = 0; k < 16; k++)
        begin
            queue_pixel(((k ^ (k >> 2)) & 1) ? 8'hFF : 8'h00, 1'b0);
        end
        drain_all();

        // widest line clamp: first row only, a border row gives no result
        write_reg(REG_FRAME_WIDTH, 12'hFFF);
        write_reg(REG_FRAME_HEIGHT, 12'hFFF);
        queue_pixels(24, 1'b1, 0);
        drain_all();

        // two full 44-wide lines; fills every store entry the later phases read
        write_reg(REG_FRAME_WIDTH, 12'd44);
        write_reg(REG_FRAME_HEIGHT, 12'd4);
        queue_pixels(2 * 44 + 12, 1'b1, 0);
        drain_all();

        // long output stall with the source still pushing
        write_reg(REG_FRAME_WIDTH, 12'd6);
        write_reg(REG_FRAME_HEIGHT, 12'd5);
        fork
            begin
                @(posedge clk) sink_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold <= 1'b0;
            end
        join_none
        queue_pixels(60, 1'b1, 0);
        drain_all();

        for (int seg = 0; seg < 6; seg++)
        begin
            send_idle_pct <= (seg < 2) ? 24 : (seg < 4) ? 69 : 0;
            recv_idle_pct <= (seg < 2) ? 69 : (seg < 4) ? 24 : 0;
            w_pick = ($urandom_range(3) == 0) ? $urandom_range(0, 40) : $urandom_range(3, 10);
            h_pick = ($urandom_range(3) == 0) ? $urandom_range(0, 12) : $urandom_range(3, 7);
            write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w_pick));
            write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h_pick));
            fresh_start = $urandom_range(99) < 70;
            queue_pixels(30, fresh_start, 3);
            drain_all();
        end

        repeat (16) @(posedge clk);
        $display("summary: %0d pixels in, %0d rgb transfers checked, %0d frame ends, %0d writes",
                 pixel_count, result_count, frame_end_count, cfg_count);
        $display("summary: geometries from clamped 3x3 to clamped 1024 wide, long output stall");
        if (error_count == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("testbench: errors");
        $finish;
    end

endmodule
